### hw/rtl/uera_pkg.sv
// Package: shared constants and types for the echo ranger averager.
`timescale 1ns / 1ps
`default_nettype none
package uera_pkg;
  localparam int NUM_CHANNELS = 5;
  localparam int CH_W = 3;
  localparam int DIST_W = 27;
  localparam int SUM_W = 43;
  localparam int CNT_W = 16;
  localparam int DUR_W = 24;
  localparam int TIME_W = 32;
  localparam int LVL_W = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] ACT_ECHO = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_PULSE = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  typedef struct packed {
    logic       echo;
    logic       tick;
    logic       clear;
  } lane_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/uera_lane.sv
// One channel lane: edge timing, distance scaling and sum accumulation.
`timescale 1ns / 1ps
`default_nettype none
module uera_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire uera_pkg::lane_ctl_t           ctl,
  input  wire logic                          level,
  input  wire logic [uera_pkg::TIME_W-1:0]   now_us,
  input  wire logic [uera_pkg::DUR_W-1:0]    scale,
  output logic [uera_pkg::SUM_W-1:0]         sum
);
  import uera_pkg::*;

  logic                echo_high;
  logic [TIME_W-1:0]   echo_start;
  logic [DIST_W-1:0]   latest;
  logic [TIME_W-1:0]   dt;
  logic [DUR_W-1:0]    dur;
  logic [47:0]         prod;
  logic [DIST_W-1:0]   range_q8;

  assign dt   = now_us - echo_start;
  assign dur  = (dt[TIME_W-1:DUR_W] != '0) ? {DUR_W{1'b1}} : dt[DUR_W-1:0];
  assign prod = 48'(dur) * 48'(scale);
  assign range_q8 = (prod[47:16+DIST_W] != '0) ? {DIST_W{1'b1}} : prod[16+DIST_W-1:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_high  <= 1'b0;
      echo_start <= '0;
      latest     <= '0;
      sum        <= '0;
    end else begin
      if (ctl.echo) begin
        if (level && !echo_high) begin
          echo_start <= now_us;
          echo_high  <= 1'b1;
        end else if (!level && echo_high) begin
          latest    <= range_q8;
          echo_high <= 1'b0;
        end
      end
      if (ctl.clear) begin
        sum <= '0;
      end else if (ctl.tick) begin
        sum <= sum + SUM_W'(latest);
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/uera_div.sv
// Shared restoring divider: sum by count, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module uera_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [uera_pkg::SUM_W-1:0]  dividend,
  input  wire logic [uera_pkg::CNT_W-1:0]  divisor,
  output logic                             done,
  output logic [uera_pkg::DIST_W-1:0]      quotient
);
  import uera_pkg::*;

  logic [SUM_W-1:0] quo;
  logic [CNT_W:0]   rem;
  logic [5:0]       bits;
  logic             busy;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   shifted;

  assign shifted = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits <= '0;
      quo  <= '0;
      rem  <= '0;
    end else begin
      done <= busy && !start && (bits == 6'd1);
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        bits <= 6'(SUM_W);
      end else if (busy) begin
        if (!trial[CNT_W]) begin
          rem <= trial;
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
        bits <= bits - 6'd1;
        if (bits == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Each sum holds at most count samples below 2^27, so the quotient fits
  // the average width; the quotient bits above are zero in use.
  assign quotient = (divisor == '0) ? '0 : quo[DIST_W-1:0];
endmodule
`default_nettype wire

### hw/rtl/ultrasonic_echo_ranger_averager.sv
// Top level: lanes per channel, trigger control, read sequencer and output register.
// Echo, tick and other non-read items: one result, registered in the cycle after the transfer.
// Read items: the sums are snapshotted, then each channel's average comes from the 43-step shared
// divider and is sent in channel order, the next channel waiting until the last result is taken.
// One item at a time: the input waits while a result is pending or a read runs.
// rst clears all state and registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_echo_ranger_averager (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [1:0]  s_tuser,  // action[1:0]
  input  wire logic [39:0] s_tdata,  // now_us[31:0], echo_levels[36:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // trigger_level, sample_taken, channel[4:2], average_q8[31:5]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import uera_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic              enable;
  logic [15:0]       pulse;
  logic [DUR_W-1:0]  scale;
  logic              trig_on;
  logic [TIME_W-1:0] trig_start;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_count;
  logic [1:0]        state;
  logic [CH_W-1:0]   ch;

  logic [1:0]        action;
  logic [TIME_W-1:0] now_us;
  logic [LVL_W-1:0]  levels;
  logic              acc;
  logic              is_echo, is_tick, is_read;
  logic              trig_next;
  logic              drop;
  logic              take;
  logic [TIME_W-1:0] tstart_eff;
  logic [TIME_W-1:0] elapsed;
  lane_ctl_t         ctl;
  logic [SUM_W-1:0]  sums [NUM_CHANNELS];
  logic [SUM_W-1:0]  div_in;
  logic              div_start, div_done;
  logic              div_busy_r;
  logic [DIST_W-1:0] quot;

  assign action = s_tuser;
  assign now_us = s_tdata[31:0];
  assign levels = s_tdata[36:32];
  assign s_tready  = (state == ST_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;
  assign acc = s_tvalid && s_tready;

  assign is_echo = acc && action == ACT_ECHO && enable;
  assign is_tick = acc && action == ACT_TICK && enable;
  assign is_read = acc && action == ACT_READ;

  assign tstart_eff = trig_on ? trig_start : now_us;
  assign elapsed    = now_us - tstart_eff;
  assign drop       = elapsed >= TIME_W'(pulse);
  assign take       = is_tick && drop && (count != COUNT_MAX);
  assign trig_next  = is_tick ? !drop : trig_on;

  assign ctl.echo  = is_echo;
  assign ctl.tick  = take;
  assign ctl.clear = is_read;

  genvar g;
  for (g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    uera_lane u_lane (
      .clk(clk), .rst(rst), .ctl(ctl), .level(levels[g]),
      .now_us(now_us), .scale(scale), .sum(sums[g])
    );
  end

  // Snapshot of sums taken at read, one per channel.
  logic [SUM_W-1:0] snap [NUM_CHANNELS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) snap[i] <= '0;
    end else if (is_read) begin
      for (int i = 0; i < NUM_CHANNELS; i++) snap[i] <= sums[i];
    end
  end

  assign div_in = snap[ch];
  assign div_start = (state == ST_DIV) && !m_tvalid && !div_busy_r;

  uera_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in),
    .divisor(rd_count), .done(div_done), .quotient(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      pulse      <= 16'd10;
      scale      <= 24'd287728;
      trig_on    <= 1'b0;
      trig_start <= '0;
      count      <= '0;
      rd_count   <= '0;
      state      <= ST_IDLE;
      ch         <= '0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
      m_tdata    <= '0;
      div_busy_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE: enable <= cfg_data[0];
          REG_PULSE:  pulse  <= cfg_data[15:0];
          REG_SCALE:  scale  <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (is_tick) begin
              if (!trig_on) trig_start <= now_us;
              trig_on <= trig_next;
            end
            if (take) count <= count + 16'd1;
            if (is_read) begin
              rd_count <= count;
              count    <= '0;
              ch       <= '0;
              state    <= ST_DIV;
            end else begin
              m_tvalid <= 1'b1;
              m_tlast  <= 1'b1;
              m_tdata  <= {27'd0, 3'd0, take, trig_next};
            end
          end
        end
        ST_DIV: begin
          if (div_start) div_busy_r <= 1'b1;
          if (div_done) begin
            div_busy_r <= 1'b0;
            m_tvalid   <= 1'b1;
            m_tlast    <= (ch == CH_W'(NUM_CHANNELS - 1));
            m_tdata    <= {quot, ch, 1'b0, trig_on};
            state      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_tvalid && m_tready) begin
            if (ch == CH_W'(NUM_CHANNELS - 1)) begin
              state <= ST_IDLE;
            end else begin
              ch    <= ch + 3'd1;
              state <= ST_DIV;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("accept while reading");
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && state == ST_OUT) |-> (ch == CH_W'(NUM_CHANNELS - 1)))
    else $error("last on wrong channel");
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    is_read |=> (count == '0)) else $error("count not cleared");
endmodule
`default_nettype wire

### test/ultrasonic_echo_ranger_averager_test.sv
// Testbench for the echo ranger averager: queued stimulus, clocked driver and monitor.
`timescale 1ns / 1ps
module ultrasonic_echo_ranger_averager_test;
  import uera_pkg::*;

  // action code with no defined meaning
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0]  levels;
    logic [TIME_W-1:0] now_us;
    logic [1:0]        action;
  } echo_item_t;

  typedef struct packed {
    logic              trig;
    logic              taken;
    logic [CH_W-1:0]   chan;
    logic [DIST_W-1:0] avg;
    logic              last;
  } range_result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [1:0] s_tuser = '0;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  ultrasonic_echo_ranger_averager dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  logic              en_r;
  logic [15:0]       pulse_r;
  logic [23:0]       scale_r;
  logic              echo_hi [NUM_CHANNELS];
  logic [31:0]       echo_t0 [NUM_CHANNELS];
  logic [DIST_W-1:0] last_dist [NUM_CHANNELS];
  logic [SUM_W-1:0]  dist_sum [NUM_CHANNELS];
  logic [CNT_W-1:0]  n_samples;
  logic              trig_hi;
  logic [31:0]       trig_t0;

  echo_item_t    pending_items[$];
  range_result_t expected_results[$];
  int errors = 0;
  int send_idle = 11, recv_idle = 82;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic logic [DIST_W-1:0] range_of(input logic [31:0] dt);
    logic [63:0] d, v;
    d = (dt > 32'hFFFFFF) ? 64'hFFFFFF : {32'd0, dt};
    v = (d * {40'd0, scale_r}) >> 16;
    if (v > 64'h7FFFFFF) v = 64'h7FFFFFF;
    return v[DIST_W-1:0];
  endfunction

  task automatic predict_ranges(input echo_item_t it);
    range_result_t r;
    logic taken;
    logic [31:0] dt;
    taken = 1'b0;
    if (it.action == ACT_READ) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        r = '0;
        r.trig = trig_hi;
        r.chan = CH_W'(i);
        r.avg = (n_samples != 0) ? DIST_W'(dist_sum[i] / n_samples) : '0;
        r.last = (i == NUM_CHANNELS - 1);
        dist_sum[i] = '0;
        expected_results.push_back(r);
      end
      n_samples = '0;
      return;
    end
    if (it.action == ACT_ECHO && en_r) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (it.levels[i] && !echo_hi[i]) begin
          echo_t0[i] = it.now_us;
          echo_hi[i] = 1'b1;
        end else if (!it.levels[i] && echo_hi[i]) begin
          last_dist[i] = range_of(it.now_us - echo_t0[i]);
          echo_hi[i] = 1'b0;
        end
      end
    end else if (it.action == ACT_TICK && en_r) begin
      if (!trig_hi) begin
        trig_hi = 1'b1;
        trig_t0 = it.now_us;
      end
      dt = it.now_us - trig_t0;
      if (dt >= {16'd0, pulse_r}) begin
        trig_hi = 1'b0;
        if (n_samples < COUNT_MAX) begin
          for (int i = 0; i < NUM_CHANNELS; i++) dist_sum[i] += SUM_W'(last_dist[i]);
          n_samples++;
          taken = 1'b1;
        end
      end
    end
    r = '0;
    r.trig = trig_hi;
    r.taken = taken;
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    echo_item_t it;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.action = s_tuser;
        it.now_us = s_tdata[31:0];
        it.levels = s_tdata[36:32];
        predict_ranges(it);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= it.action;
          s_tdata  <= {3'd0, it.levels, it.now_us};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    range_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[1], m_tdata[4:2], m_tdata[31:5], m_tlast};
      if (expected_results.size() == 0) report("result with nothing expected");
      else begin
        want = expected_results.pop_front();
        if (got.trig !== want.trig) report("trigger_level");
        if (got.taken !== want.taken) report("sample_taken");
        if (got.chan !== want.chan) report("channel");
        if (got.avg !== want.avg) report("average_q8");
        if (got.last !== want.last) report("last");
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE: en_r = val[0];
      REG_PULSE:  pulse_r = val[15:0];
      default:    scale_r = val;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic push(input logic [1:0] a, input logic [31:0] t, input logic [4:0] l);
    echo_item_t it;
    it.action = a;
    it.now_us = t;
    it.levels = l;
    pending_items.push_back(it);
  endtask

  // one ranging cycle: echo rise, fall, tick pair
  task automatic push_cycle(inout logic [31:0] t);
    logic [4:0] l;
    l = 5'($urandom);
    push(ACT_ECHO, t, l);
    t += $urandom_range(3000);
    push(ACT_ECHO, t, l & 5'($urandom));
    push(ACT_TICK, t, 5'd0);
    t += $urandom_range(40);
    push(ACT_TICK, t, 5'd0);
    t += $urandom_range(100);
  endtask

  initial begin
    logic [31:0] t;
    en_r = 1'b1; pulse_r = 16'd10; scale_r = 24'd287728;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      echo_hi[i] = 1'b0; echo_t0[i] = '0; last_dist[i] = '0; dist_sum[i] = '0;
    end
    n_samples = '0; trig_hi = 1'b0; trig_t0 = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    // directed: wrap, saturation, undefined action, zero pulse, disabled
    push(ACT_UNUSED, 32'hFFFFFFFF, 5'h1F);
    push(ACT_READ, 32'd0, 5'd0);
    push(ACT_ECHO, 32'hFFFFFFF0, 5'h1F);
    push(ACT_ECHO, 32'h00000010, 5'h0A);
    push(ACT_ECHO, 32'h7FFFFFFF, 5'h00);
    push(ACT_TICK, 32'd100, 5'd0);
    push(ACT_TICK, 32'd105, 5'd0);
    push(ACT_TICK, 32'd110, 5'd0);
    push(ACT_READ, 32'd200, 5'h1F);
    drain();
    write_reg(REG_SCALE, 24'hFFFFFF);
    write_reg(REG_PULSE, 24'd0);
    push(ACT_ECHO, 32'd0, 5'h15);
    push(ACT_ECHO, 32'h00FFFFFF, 5'h00);
    push(ACT_TICK, 32'd5, 5'd0);
    push(ACT_TICK, 32'd9, 5'h1F);
    push(ACT_READ, 32'd9, 5'd0);
    drain();
    write_reg(REG_ENABLE, 24'd0);
    push(ACT_ECHO, 32'd1, 5'h1F);
    push(ACT_TICK, 32'd2, 5'd0);
    push(ACT_READ, 32'd3, 5'd0);
    drain();
    write_reg(REG_ENABLE, 24'd1);
    write_reg(REG_PULSE, 24'hFFFF);
    write_reg(REG_SCALE, 24'd0);
    push(ACT_TICK, 32'hFFFFFF00, 5'd0);
    push(ACT_TICK, 32'h0000FEFF, 5'd0);
    push(ACT_TICK, 32'h0000FF00, 5'd0);
    drain();
    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 82; recv_idle = 11; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      write_reg(REG_PULSE, 24'($urandom_range(30)));
      write_reg(REG_SCALE, (ph == 0) ? 24'd287728 : 24'($urandom));
      t = $urandom;
      for (int k = 0; k < 23; k++) begin
        if ($urandom_range(5) == 0)
          push(2'($urandom), $urandom, 5'($urandom));
        else push_cycle(t);
        if (k % 6 == 5) push(ACT_READ, t, 5'($urandom));
      end
      drain();
    end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
